@@ design/diag_frame_receive_filter_defines.svh @@
// assertion macros for the diagnostic frame receive filter
`ifndef DIAG_FRAME_RECEIVE_FILTER_DEFINES_SVH
`define DIAG_FRAME_RECEIVE_FILTER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// checked on every rising edge, quiet while reset is held
`define DFRF_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("dfrf assertion failed");

// checked on every rising edge, reset included
`define DFRF_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("dfrf assertion failed");

`else

`define DFRF_ASSERT(label, clk, rst_n, prop)
`define DFRF_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

@@ design/dfrf_pkg.sv @@
`timescale 1ns / 1ps

package dfrf_pkg;

  localparam int unsigned PAYLOAD_BYTES_DEF = 16;
  localparam int unsigned HDR_BYTES         = 14;

  // frame layout, byte offsets from the first wire byte
  localparam int unsigned DEST_END  = 6;
  localparam int unsigned SRC_END   = 12;
  localparam int unsigned TYPE_END  = 14;
  localparam int unsigned MAGIC_END = 19;
  localparam int unsigned KIND_POS  = 19;
  localparam int unsigned SEQ_END   = 22;

  localparam int unsigned MAC_W  = 48;
  localparam int unsigned TYPE_W = 16;
  localparam int unsigned KIND_W = 8;
  localparam int unsigned SEQ_W  = 16;

  localparam logic [7:0]        BCAST_BYTE    = 8'hff;
  localparam logic [TYPE_W-1:0] FRAME_TYPE_RST = 16'h88b5;

  // "PMRP" then version 1
  localparam logic [7:0] MAGIC [5] = '{8'h50, 8'h4d, 8'h52, 8'h50, 8'h01};

  typedef enum logic [1:0] {
    REG_PEER_ADDR  = 2'd0,
    REG_LOCAL_ADDR = 2'd1,
    REG_FRAME_TYPE = 2'd2
  } reg_idx_e;

  typedef enum logic [2:0] {
    VERDICT_ACCEPT   = 3'd0,
    VERDICT_OUTGOING = 3'd1,
    VERDICT_SHORT    = 3'd2,
    VERDICT_TYPE     = 3'd3,
    VERDICT_SOURCE   = 3'd4,
    VERDICT_DEST     = 3'd5,
    VERDICT_PAYLOAD  = 3'd6
  } verdict_e;

  typedef struct packed {
    logic [SEQ_W-1:0]  sequence_res;
    logic [KIND_W-1:0] message_kind;
    verdict_e          verdict;
  } result_t;

endpackage

@@ design/diag_frame_receive_filter.sv @@
// latency: a result word appears on the master side in the cycle after the final byte is taken
// throughput: one byte per cycle unless a held output word stalls the input; the byte compare
//   and verdict logic sit between the frame state registers and a single output register
// the input is taken while the output register is empty or being drained
// reset: asynchronous, active low; clears frame state, output valid and the registers
//   (addresses to zero, frame type to 0x88b5)
`timescale 1ns / 1ps

`include "diag_frame_receive_filter_defines.svh"

module diag_frame_receive_filter #(
  parameter int unsigned PAYLOAD_BYTES = dfrf_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [47:0] cfg_data_i,

  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] frame_byte
  input  logic        s_axis_tlast,   // end_of_frame
  input  logic        s_axis_tuser,   // own_transmit

  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // [2:0] verdict, [10:3] message_kind,
                                      // [26:11] sequence_res, [31:27] zero
);

  localparam int unsigned MIN_FRAME = dfrf_pkg::HDR_BYTES + PAYLOAD_BYTES;
  localparam int unsigned POS_W     = $clog2(MIN_FRAME + 1);
  localparam int unsigned RES_W     = $bits(dfrf_pkg::result_t);

  localparam logic [POS_W-1:0] P_DEST  = POS_W'(dfrf_pkg::DEST_END);
  localparam logic [POS_W-1:0] P_SRC   = POS_W'(dfrf_pkg::SRC_END);
  localparam logic [POS_W-1:0] P_TYPE  = POS_W'(dfrf_pkg::TYPE_END);
  localparam logic [POS_W-1:0] P_MAGIC = POS_W'(dfrf_pkg::MAGIC_END);
  localparam logic [POS_W-1:0] P_KIND  = POS_W'(dfrf_pkg::KIND_POS);
  localparam logic [POS_W-1:0] P_SEQ   = POS_W'(dfrf_pkg::SEQ_END);
  localparam logic [POS_W-1:0] P_MIN   = POS_W'(MIN_FRAME);

  // configuration
  logic [dfrf_pkg::MAC_W-1:0]  peer_addr_q, local_addr_q;
  logic [dfrf_pkg::TYPE_W-1:0] frame_type_q;

  // frame state
  logic [POS_W-1:0]            pos_q, pos_d, pos_upd;
  logic                        dst_local_q, dst_local_d, dst_local_upd;
  logic                        dst_bcast_q, dst_bcast_d, dst_bcast_upd;
  logic                        src_ok_q, src_ok_d, src_ok_upd;
  logic                        magic_ok_q, magic_ok_d, magic_ok_upd;
  logic [dfrf_pkg::TYPE_W-1:0] rx_type_q, rx_type_d, rx_type_upd;
  logic [dfrf_pkg::KIND_W-1:0] kind_q, kind_d, kind_upd;
  logic [dfrf_pkg::SEQ_W-1:0]  seq_q, seq_d, seq_upd;

  // output register
  logic                        out_valid_q, out_valid_d;
  dfrf_pkg::result_t           out_res_q, out_res_d;

  logic                        in_acc;
  logic [7:0]                  rx_byte;
  logic [2:0]                  dst_sel, src_sel, mag_idx;
  logic [7:0]                  dst_ref, src_ref;
  dfrf_pkg::verdict_e          verdict;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign rx_byte       = s_axis_tdata;

  // address bytes go out most significant first
  assign dst_sel = 3'(P_DEST - 1'b1 - pos_q);
  assign src_sel = 3'(P_SRC - 1'b1 - pos_q);
  assign mag_idx = 3'(pos_q - P_TYPE);
  assign dst_ref = local_addr_q[{dst_sel, 3'b000} +: 8];
  assign src_ref = peer_addr_q[{src_sel, 3'b000} +: 8];

  always_comb begin
    dst_local_upd = dst_local_q;
    dst_bcast_upd = dst_bcast_q;
    src_ok_upd    = src_ok_q;
    magic_ok_upd  = magic_ok_q;
    rx_type_upd   = rx_type_q;
    kind_upd      = kind_q;
    seq_upd       = seq_q;
    if (pos_q < P_DEST) begin
      if (rx_byte != dst_ref) dst_local_upd = 1'b0;
      if (rx_byte != dfrf_pkg::BCAST_BYTE) dst_bcast_upd = 1'b0;
    end else if (pos_q < P_SRC) begin
      if (rx_byte != src_ref) src_ok_upd = 1'b0;
    end else if (pos_q < P_TYPE) begin
      rx_type_upd = {rx_type_q[7:0], rx_byte};
    end else if (pos_q < P_MAGIC) begin
      if (rx_byte != dfrf_pkg::MAGIC[mag_idx]) magic_ok_upd = 1'b0;
    end else if (pos_q == P_KIND) begin
      kind_upd = rx_byte;
    end else if (pos_q < P_SEQ) begin
      seq_upd = {seq_q[7:0], rx_byte};
    end
    // counter saturates at the minimum frame length
    pos_upd = (pos_q < P_MIN) ? pos_q + 1'b1 : pos_q;
  end

  always_comb begin
    if (s_axis_tuser) begin
      verdict = dfrf_pkg::VERDICT_OUTGOING;
    end else if (pos_upd < P_MIN) begin
      verdict = dfrf_pkg::VERDICT_SHORT;
    end else if (rx_type_upd != frame_type_q) begin
      verdict = dfrf_pkg::VERDICT_TYPE;
    end else if (!src_ok_upd) begin
      verdict = dfrf_pkg::VERDICT_SOURCE;
    end else if (!dst_local_upd && !dst_bcast_upd) begin
      verdict = dfrf_pkg::VERDICT_DEST;
    end else if (!magic_ok_upd) begin
      verdict = dfrf_pkg::VERDICT_PAYLOAD;
    end else begin
      verdict = dfrf_pkg::VERDICT_ACCEPT;
    end
  end

  always_comb begin
    pos_d       = pos_q;
    dst_local_d = dst_local_q;
    dst_bcast_d = dst_bcast_q;
    src_ok_d    = src_ok_q;
    magic_ok_d  = magic_ok_q;
    rx_type_d   = rx_type_q;
    kind_d      = kind_q;
    seq_d       = seq_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_res_d   = out_res_q;
    if (in_acc) begin
      if (s_axis_tlast) begin
        // frame done: back to the idle frame state
        pos_d       = '0;
        dst_local_d = 1'b1;
        dst_bcast_d = 1'b1;
        src_ok_d    = 1'b1;
        magic_ok_d  = 1'b1;
        rx_type_d   = '0;
        kind_d      = '0;
        seq_d       = '0;
        out_valid_d = 1'b1;
        out_res_d.verdict = verdict;
        if (verdict == dfrf_pkg::VERDICT_ACCEPT) begin
          out_res_d.message_kind = kind_upd;
          out_res_d.sequence_res = seq_upd;
        end else begin
          out_res_d.message_kind = '0;
          out_res_d.sequence_res = '0;
        end
      end else begin
        pos_d       = pos_upd;
        dst_local_d = dst_local_upd;
        dst_bcast_d = dst_bcast_upd;
        src_ok_d    = src_ok_upd;
        magic_ok_d  = magic_ok_upd;
        rx_type_d   = rx_type_upd;
        kind_d      = kind_upd;
        seq_d       = seq_upd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peer_addr_q  <= '0;
      local_addr_q <= '0;
      frame_type_q <= dfrf_pkg::FRAME_TYPE_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        dfrf_pkg::REG_PEER_ADDR:  peer_addr_q  <= cfg_data_i;
        dfrf_pkg::REG_LOCAL_ADDR: local_addr_q <= cfg_data_i;
        dfrf_pkg::REG_FRAME_TYPE: frame_type_q <= cfg_data_i[dfrf_pkg::TYPE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      dst_local_q <= 1'b1;
      dst_bcast_q <= 1'b1;
      src_ok_q    <= 1'b1;
      magic_ok_q  <= 1'b1;
      rx_type_q   <= '0;
      kind_q      <= '0;
      seq_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      dst_local_q <= dst_local_d;
      dst_bcast_q <= dst_bcast_d;
      src_ok_q    <= src_ok_d;
      magic_ok_q  <= magic_ok_d;
      rx_type_q   <= rx_type_d;
      kind_q      <= kind_d;
      seq_q       <= seq_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q <= out_res_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(32 - RES_W)'(0), out_res_q};

  `DFRF_ASSERT_ALWAYS(a_pos_saturates, clk_i, pos_q <= P_MIN)
  `DFRF_ASSERT(a_last_gives_word, clk_i, rst_ni, in_acc && s_axis_tlast |=> out_valid_q)
  `DFRF_ASSERT(a_last_clears_pos, clk_i, rst_ni, in_acc && s_axis_tlast |=> pos_q == '0)
  `DFRF_ASSERT(a_fields_zero_unless_accept, clk_i, rst_ni,
    out_valid_q && out_res_q.verdict != dfrf_pkg::VERDICT_ACCEPT |->
      out_res_q.message_kind == '0 && out_res_q.sequence_res == '0)

endmodule
